// File: sv/tch_pkg.sv
// shared types, constants and the arctangent table for the heading pipeline
// no dependencies
package tch_pkg;

  localparam int DW = 32;
  localparam int AW = 16;
  localparam int ZW = 18;
  localparam int TABLE_LEN = 24;
  localparam int CORDIC_ITERATIONS_DEF = 16;
  localparam int KINV_Q16 = 39797;
  localparam int QUARTER = 16384;
  localparam int FULL_DEG = 360;
  localparam int MAX_DEG = 359;
  localparam int IN_W = 96;
  localparam int OUT_W = 16;
  localparam int DEG_W = 9;

  typedef logic signed [DW-1:0] dat_t;
  typedef logic [AW-1:0] ang_t;

  function automatic ang_t atan_tab(input logic [4:0] i);
    ang_t r;
    unique case (i)
      5'd0:    r = 16'd8192;
      5'd1:    r = 16'd4836;
      5'd2:    r = 16'd2555;
      5'd3:    r = 16'd1297;
      5'd4:    r = 16'd651;
      5'd5:    r = 16'd326;
      5'd6:    r = 16'd163;
      5'd7:    r = 16'd81;
      5'd8:    r = 16'd41;
      5'd9:    r = 16'd20;
      5'd10:   r = 16'd10;
      5'd11:   r = 16'd5;
      5'd12:   r = 16'd3;
      5'd13:   r = 16'd1;
      5'd14:   r = 16'd1;
      default: r = 16'd0;
    endcase
    return r;
  endfunction

  function automatic dat_t scale17(input logic [16:0] v);
    return {{7{v[16]}}, v, 8'b0};
  endfunction

  function automatic dat_t scale15(input logic [14:0] v);
    return {{9{v[14]}}, v, 8'b0};
  endfunction

endpackage

// File: sv/tch_gain.sv
// one register stage that multiplies by the inverse cordic gain
// depends on tch_pkg
module tch_gain #(
  parameter int SB_W = 1
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 en,
  input  logic                 in_valid,
  input  tch_pkg::dat_t        in_v,
  input  logic [SB_W-1:0]      in_side,
  output logic                 out_valid,
  output tch_pkg::dat_t        out_v,
  output logic [SB_W-1:0]      out_side
);

  logic signed [48:0] prod;
  logic               valid_r;
  tch_pkg::dat_t      v_r;
  logic [SB_W-1:0]    side_r;

  assign prod = 49'(in_v) * 49'(tch_pkg::KINV_Q16);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      v_r    <= prod[47:16];
      side_r <= in_side;
    end
  end

  assign out_valid = valid_r;
  assign out_v     = v_r;
  assign out_side  = side_r;

endmodule

// File: sv/tch_vec.sv
// pipelined vectoring cordic: angle and scaled length of (x, y)
// depends on tch_pkg
module tch_vec #(
  parameter int N    = tch_pkg::CORDIC_ITERATIONS_DEF,
  parameter int SB_W = 1
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 en,
  input  logic                 in_valid,
  input  tch_pkg::dat_t        in_x,
  input  tch_pkg::dat_t        in_y,
  input  logic [SB_W-1:0]      in_side,
  output logic                 out_valid,
  output tch_pkg::ang_t        out_z,
  output tch_pkg::dat_t        out_len,
  output logic [SB_W-1:0]      out_side
);

  tch_pkg::dat_t   x_r  [0:N];
  tch_pkg::dat_t   y_r  [0:N];
  tch_pkg::ang_t   z_r  [0:N];
  logic            zf_r [0:N];
  logic [SB_W-1:0] sd_r [0:N];
  logic            vl_r [0:N];

  tch_pkg::dat_t x0, y0;
  tch_pkg::ang_t z0;

  always_comb begin
    x0 = in_x;
    y0 = in_y;
    z0 = '0;
    if (in_x[tch_pkg::DW-1]) begin
      if (!in_y[tch_pkg::DW-1]) begin
        x0 = in_y;
        y0 = -in_x;
        z0 = tch_pkg::AW'(tch_pkg::QUARTER);
      end else begin
        x0 = -in_y;
        y0 = in_x;
        z0 = -tch_pkg::AW'(tch_pkg::QUARTER);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vl_r[0] <= 1'b0;
    end else if (en) begin
      vl_r[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_r[0]  <= x0;
      y_r[0]  <= y0;
      z_r[0]  <= z0;
      zf_r[0] <= (in_x == '0) && (in_y == '0);
      sd_r[0] <= in_side;
    end
  end

  for (genvar k = 0; k < N; k++) begin : g_it
    tch_pkg::dat_t dx, dy;
    tch_pkg::ang_t t;
    assign dx = x_r[k] >>> k;
    assign dy = y_r[k] >>> k;
    assign t  = tch_pkg::atan_tab(5'(k));

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vl_r[k+1] <= 1'b0;
      end else if (en) begin
        vl_r[k+1] <= vl_r[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        if (!y_r[k][tch_pkg::DW-1]) begin
          x_r[k+1] <= x_r[k] + dy;
          y_r[k+1] <= y_r[k] - dx;
          z_r[k+1] <= z_r[k] + t;
        end else begin
          x_r[k+1] <= x_r[k] - dy;
          y_r[k+1] <= y_r[k] + dx;
          z_r[k+1] <= z_r[k] - t;
        end
        zf_r[k+1] <= zf_r[k];
        sd_r[k+1] <= sd_r[k];
      end
    end
  end

  assign out_valid = vl_r[N];
  assign out_z     = zf_r[N] ? '0 : z_r[N];
  assign out_len   = x_r[N];
  assign out_side  = sd_r[N];

endmodule

// File: sv/tch_rot.sv
// pipelined rotation cordic: turns (x, y) by a binary angle, gain included
// depends on tch_pkg
module tch_rot #(
  parameter int N    = tch_pkg::CORDIC_ITERATIONS_DEF,
  parameter int SB_W = 1
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 en,
  input  logic                 in_valid,
  input  tch_pkg::dat_t        in_x,
  input  tch_pkg::dat_t        in_y,
  input  tch_pkg::ang_t        in_a,
  input  logic [SB_W-1:0]      in_side,
  output logic                 out_valid,
  output tch_pkg::dat_t        out_x,
  output tch_pkg::dat_t        out_y,
  output logic [SB_W-1:0]      out_side
);

  localparam int ZW = tch_pkg::ZW;

  tch_pkg::dat_t         x_r  [0:N];
  tch_pkg::dat_t         y_r  [0:N];
  logic signed [ZW-1:0]  z_r  [0:N];
  logic [SB_W-1:0]       sd_r [0:N];
  logic                  vl_r [0:N];

  tch_pkg::dat_t        x0, y0;
  logic signed [ZW-1:0] za, z0;

  assign za = ZW'($signed(in_a));

  always_comb begin
    x0 = in_x;
    y0 = in_y;
    z0 = za;
    if (za > ZW'(tch_pkg::QUARTER)) begin
      x0 = -in_y;
      y0 = in_x;
      z0 = za - ZW'(tch_pkg::QUARTER);
    end else if (za < -ZW'(tch_pkg::QUARTER)) begin
      x0 = in_y;
      y0 = -in_x;
      z0 = za + ZW'(tch_pkg::QUARTER);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vl_r[0] <= 1'b0;
    end else if (en) begin
      vl_r[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_r[0]  <= x0;
      y_r[0]  <= y0;
      z_r[0]  <= z0;
      sd_r[0] <= in_side;
    end
  end

  for (genvar k = 0; k < N; k++) begin : g_it
    tch_pkg::dat_t        dx, dy;
    logic signed [ZW-1:0] t;
    assign dx = x_r[k] >>> k;
    assign dy = y_r[k] >>> k;
    assign t  = ZW'(tch_pkg::atan_tab(5'(k)));

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vl_r[k+1] <= 1'b0;
      end else if (en) begin
        vl_r[k+1] <= vl_r[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        if (!z_r[k][ZW-1]) begin
          x_r[k+1] <= x_r[k] - dy;
          y_r[k+1] <= y_r[k] + dx;
          z_r[k+1] <= z_r[k] - t;
        end else begin
          x_r[k+1] <= x_r[k] + dy;
          y_r[k+1] <= y_r[k] - dx;
          z_r[k+1] <= z_r[k] + t;
        end
        sd_r[k+1] <= sd_r[k];
      end
    end
  end

  assign out_valid = vl_r[N];
  assign out_x     = x_r[N];
  assign out_y     = y_r[N];
  assign out_side  = sd_r[N];

endmodule

// File: sv/tilt_compensated_heading.sv
// top level: tilt compensated compass heading from accel and mag samples
// depends on tch_pkg, tch_vec, tch_rot, tch_gain
//
// channel  dir  handshake            payload
// in_      in   in_tvalid/in_tready   in_tdata: mag_x, mag_y, mag_z, acc_x, acc_y, acc_z
// out_     out  out_tvalid/out_tready out_tdata: heading_deg
//
// one item per cycle unless the output stalls; N = CORDIC_ITERATIONS cordic iterations, capped at 24
// rate is set by the fully pipelined cordic units, one stage per iteration
// the whole pipeline advances when the output register is empty or taken
// a stall freezes every stage; reset clears only the valid bits
module tilt_compensated_heading #(
  parameter int CORDIC_ITERATIONS = tch_pkg::CORDIC_ITERATIONS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_tvalid,
  output logic                       in_tready,
  // mag_x[16:0] mag_y[33:17] mag_z[50:34] acc_x[65:51] acc_y[80:66] acc_z[95:81]
  input  logic [tch_pkg::IN_W-1:0]   in_tdata,
  output logic                       out_tvalid,
  input  logic                       out_tready,
  // heading_deg[8:0], zeros above
  output logic [tch_pkg::OUT_W-1:0]  out_tdata
);

  localparam int N = (CORDIC_ITERATIONS > tch_pkg::TABLE_LEN) ?
                     tch_pkg::TABLE_LEN : CORDIC_ITERATIONS;

  logic en;
  logic out_tvalid_r;
  logic [tch_pkg::DEG_W-1:0] deg_r, deg_nxt;

  assign en        = !out_tvalid_r || out_tready;
  assign in_tready = en;

  // roll
  logic          a_v;
  tch_pkg::ang_t a_roll;
  tch_pkg::dat_t a_len;
  logic [65:0]   a_sd;

  tch_vec #(.N(N), .SB_W(66)) u_roll (
    .clk, .rst_n, .en,
    .in_valid (in_tvalid && in_tready),
    .in_x     (tch_pkg::scale15(in_tdata[95:81])),
    .in_y     (tch_pkg::scale15(in_tdata[80:66])),
    .in_side  (in_tdata[65:0]),
    .out_valid(a_v), .out_z(a_roll), .out_len(a_len), .out_side(a_sd)
  );

  logic          g1_v;
  tch_pkg::dat_t g1_len;
  logic [81:0]   g1_sd;

  tch_gain #(.SB_W(82)) u_gain_len (
    .clk, .rst_n, .en,
    .in_valid(a_v), .in_v(a_len), .in_side({a_roll, a_sd}),
    .out_valid(g1_v), .out_v(g1_len), .out_side(g1_sd)
  );

  // pitch
  logic          b_v;
  tch_pkg::ang_t b_pitch;
  logic [66:0]   b_sd;

  tch_vec #(.N(N), .SB_W(67)) u_pitch (
    .clk, .rst_n, .en,
    .in_valid(g1_v),
    .in_x    (g1_len),
    .in_y    (-tch_pkg::scale15(g1_sd[65:51])),
    .in_side ({g1_sd[81:66], g1_sd[50:0]}),
    .out_valid(b_v), .out_z(b_pitch), .out_len(), .out_side(b_sd)
  );

  // mag (z, y) turned by -roll
  logic          c_v;
  tch_pkg::dat_t c_x, c_y;
  logic [32:0]   c_sd;

  tch_rot #(.N(N), .SB_W(33)) u_rot_roll (
    .clk, .rst_n, .en,
    .in_valid(b_v),
    .in_x    (tch_pkg::scale17(b_sd[50:34])),
    .in_y    (tch_pkg::scale17(b_sd[33:17])),
    .in_a    (-b_sd[66:51]),
    .in_side ({b_pitch, b_sd[16:0]}),
    .out_valid(c_v), .out_x(c_x), .out_y(c_y), .out_side(c_sd)
  );

  logic          g2_v;
  tch_pkg::dat_t g2_t;
  logic [64:0]   g2_sd;

  tch_gain #(.SB_W(65)) u_gain_t (
    .clk, .rst_n, .en,
    .in_valid(c_v), .in_v(c_x), .in_side({-c_y, c_sd}),
    .out_valid(g2_v), .out_v(g2_t), .out_side(g2_sd)
  );

  // mag (x, t) turned by -pitch
  logic          d_v;
  tch_pkg::dat_t d_x;
  tch_pkg::dat_t d_hy;

  tch_rot #(.N(N), .SB_W(tch_pkg::DW)) u_rot_pitch (
    .clk, .rst_n, .en,
    .in_valid(g2_v),
    .in_x    (tch_pkg::scale17(g2_sd[16:0])),
    .in_y    (g2_t),
    .in_a    (-g2_sd[32:17]),
    .in_side (g2_sd[64:33]),
    .out_valid(d_v), .out_x(d_x), .out_y(), .out_side(d_hy)
  );

  // heading
  logic          e_v;
  tch_pkg::ang_t e_h;

  tch_vec #(.N(N), .SB_W(1)) u_head (
    .clk, .rst_n, .en,
    .in_valid(d_v), .in_x(d_x), .in_y(d_hy), .in_side(1'b0),
    .out_valid(e_v), .out_z(e_h), .out_len(), .out_side()
  );

  logic [24:0] deg_prod;

  assign deg_prod = 25'(e_h) * 25'(tch_pkg::FULL_DEG);

  always_comb begin
    deg_nxt = deg_prod[24:16];
    if (deg_nxt > tch_pkg::DEG_W'(tch_pkg::MAX_DEG)) begin
      deg_nxt = tch_pkg::DEG_W'(tch_pkg::MAX_DEG);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (en) begin
      out_tvalid_r <= e_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      deg_r <= deg_nxt;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {{(tch_pkg::OUT_W-tch_pkg::DEG_W){1'b0}}, deg_r};

`ifndef SYNTHESIS
  a_deg_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata < tch_pkg::OUT_W'(tch_pkg::FULL_DEG)))
    else $error("heading out of range");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> (out_tvalid && $stable(out_tdata)))
    else $error("result dropped during stall");

  a_reset_empty: assert property (@(posedge clk)
    (rst_n && $past(!rst_n)) |-> !out_tvalid)
    else $error("output valid right after reset");
`endif

endmodule
